>>> hw/rtl/interval_jitter_histogram_macros.svh
// Assertion helpers used by the RTL.
`ifndef INTERVAL_JITTER_HISTOGRAM_MACROS_SVH
`define INTERVAL_JITTER_HISTOGRAM_MACROS_SVH

// Checked on every rising edge outside reset.
`define IJH_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define IJH_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> hw/rtl/ijh_pkg.sv
package ijh_pkg;

  localparam int unsigned NUM_EDGES_DEF = 10;

  localparam int unsigned TS_W  = 32;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned SEL_W = 4;

  // stream payload widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 104;

  // register index = paddr[3:2]
  localparam logic [1:0] REG_ENABLE     = 2'd0;
  localparam logic [1:0] REG_FIRST_EDGE = 2'd1;
  localparam logic [1:0] REG_BIN_STEP   = 2'd2;

  typedef struct packed {
    logic              enable;
    logic [TS_W-1:0]   first_edge_us;
    logic [TS_W-1:0]   bin_step_us;
  } ijh_cfg_t;

endpackage

>>> hw/rtl/ijh_mem.sv
module ijh_mem #(
  parameter int unsigned DEPTH = 11,
  parameter int unsigned AW    = 4,
  parameter int unsigned DW    = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i
);

  logic [DW-1:0]    mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [DW-1:0]    rd_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // per-entry valid bits: an entry not yet written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

>>> hw/rtl/ijh_bin_sel.sv
module ijh_bin_sel #(
  parameter int unsigned NUM_EDGES = 10,
  parameter int unsigned BW        = 4
) (
  input  ijh_pkg::ijh_cfg_t          cfg_i,
  input  logic [ijh_pkg::TS_W-1:0]   interval_i,
  output logic [BW-1:0]              bin_o
);
  import ijh_pkg::*;

  // edge sums are exact: 32 bits plus index growth plus carry
  localparam int unsigned EW = TS_W + 1 + $clog2(NUM_EDGES + 1);

  logic [NUM_EDGES-1:0] lt;
  logic [NUM_EDGES-1:0] hit;

  always_comb begin
    logic [EW-1:0] edg;
    for (int i = 0; i < NUM_EDGES; i++) begin
      edg   = EW'(cfg_i.first_edge_us) + EW'(cfg_i.bin_step_us) * EW'(i);
      lt[i] = EW'(interval_i) < edg;
    end
  end

  // edges never decrease, so lt is a thermometer; hit marks its first set bit
  always_comb begin
    hit[0] = lt[0];
    for (int i = 1; i < NUM_EDGES; i++) begin
      hit[i] = lt[i] & ~lt[i-1];
    end
  end

  always_comb begin
    logic [BW-1:0] enc;
    enc = '0;
    for (int i = 0; i < NUM_EDGES; i++) begin
      enc = enc | (hit[i] ? BW'(i) : '0);
    end
    bin_o = (lt == '0) ? BW'(NUM_EDGES) : enc;
  end

endmodule

>>> hw/rtl/interval_jitter_histogram.sv
// Interval jitter histogram. Each stream transaction is either an interval
// event (tuser = 0) carrying a free-running microsecond stamp, or a read of
// one bin count (tuser = 1). While enabled, the first event only latches its
// stamp; each later event measures the wrapping difference from the previous
// stamp and bumps bin i, the first i with interval < first_edge_us +
// i * bin_step_us, or the top bin NUM_EDGES when no edge is reached. Bin
// counts and the interval total saturate at 2^32-1. Every input transaction
// yields exactly one output transaction. Throughput is one transaction per
// cycle while the output is not held by back-pressure; there are three
// register stages (capture and interval subtract, compare bank plus bin
// memory read, then saturating increment plus write-back into the output
// register). The bin memory has one read and one write port; a back-to-back
// hit on the same bin is forwarded from the write stage. Counts clear at
// reset through per-bin valid bits, so no clearing pass is needed.
// Registers: 0x0 enable, 0x4 first_edge_us, 0x8 bin_step_us; write them only
// while the block is idle.
`include "interval_jitter_histogram_macros.svh"

module interval_jitter_histogram #(
  parameter int unsigned NUM_EDGES = ijh_pkg::NUM_EDGES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // APB configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [3:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [31:0] timestamp_us, [35:32] bin_select, [39:36] zero
  input  logic [ijh_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [0] mode
  input  logic [0:0]                         s_axis_tuser,
  // output stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [3:0] bin, [35:4] bin_count, [67:36] total_intervals,
  // [99:68] interval_us, [103:100] zero
  output logic [ijh_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // [0] recorded
  output logic [0:0]                         m_axis_tuser
);
  import ijh_pkg::*;

  localparam int unsigned NBINS = NUM_EDGES + 1;
  localparam int unsigned BW    = $clog2(NBINS);

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_REC,
    KIND_READ
  } kind_e;

  localparam logic [CNT_W-1:0] SAT = '1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  ijh_cfg_t cfg_q;
  logic     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ENABLE:     cfg_q.enable        <= pwdata[0];
        REG_FIRST_EDGE: cfg_q.first_edge_us <= pwdata;
        REG_BIN_STEP:   cfg_q.bin_step_us   <= pwdata;
        default: ;  // unknown register, ignored
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ENABLE:     prdata = {31'd0, cfg_q.enable};
      REG_FIRST_EDGE: prdata = cfg_q.first_edge_us;
      REG_BIN_STEP:   prdata = cfg_q.bin_step_us;
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: each stage moves when the one ahead is free
  // ---------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, out_v_q;
  logic adv_out, adv2, adv1, in_acc;

  assign adv_out       = !out_v_q || m_axis_tready;
  assign adv2          = !s2_v_q || adv_out;
  assign adv1          = !s1_v_q || adv2;
  assign s_axis_tready = adv1;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // Capture: classify the transaction, measure the interval, update the stamp
  // ---------------------------------------------------------------------------
  logic              in_mode;
  logic [TS_W-1:0]   in_stamp;
  logic [SEL_W-1:0]  in_sel;
  kind_e             in_kind;

  logic              seen_first_q;
  logic [TS_W-1:0]   last_stamp_q;

  kind_e             s1_kind_q;
  logic [TS_W-1:0]   s1_ivl_q;
  logic [SEL_W-1:0]  s1_sel_q;

  assign in_mode  = s_axis_tuser[0];
  assign in_stamp = s_axis_tdata[TS_W-1:0];
  assign in_sel   = s_axis_tdata[TS_W+SEL_W-1:TS_W];

  always_comb begin
    if (in_mode) begin
      in_kind = KIND_READ;
    end else if (cfg_q.enable && seen_first_q) begin
      in_kind = KIND_REC;
    end else begin
      in_kind = KIND_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_first_q <= 1'b0;
      last_stamp_q <= '0;
      s1_v_q       <= 1'b0;
    end else begin
      if (in_acc && !in_mode && cfg_q.enable) begin
        seen_first_q <= 1'b1;
        last_stamp_q <= in_stamp;
      end
      if (adv1) begin
        s1_v_q <= in_acc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_kind_q <= in_kind;
      s1_ivl_q  <= (in_kind == KIND_REC) ? (in_stamp - last_stamp_q) : '0;
      s1_sel_q  <= in_sel;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: compare bank picks the bin, bin memory read issued
  // ---------------------------------------------------------------------------
  logic [BW-1:0]     s1_bin;
  logic              s1_sel_ok;
  logic [BW-1:0]     rd_addr;
  logic [SEL_W-1:0]  s1_bin_out;
  logic              s1_zero;
  logic              rd_en;

  ijh_bin_sel #(
    .NUM_EDGES (NUM_EDGES),
    .BW        (BW)
  ) u_bin_sel (
    .cfg_i      (cfg_q),
    .interval_i (s1_ivl_q),
    .bin_o      (s1_bin)
  );

  assign s1_sel_ok = 32'(s1_sel_q) < 32'(NBINS);
  assign rd_en     = s1_v_q && adv2;

  always_comb begin
    case (s1_kind_q)
      KIND_REC: begin
        rd_addr    = s1_bin;
        s1_bin_out = SEL_W'(s1_bin);
        s1_zero    = 1'b0;
      end
      KIND_READ: begin
        rd_addr    = s1_sel_ok ? BW'(s1_sel_q) : '0;
        s1_bin_out = s1_sel_q;
        s1_zero    = !s1_sel_ok;  // bin beyond the histogram reads zero
      end
      default: begin
        rd_addr    = '0;
        s1_bin_out = '0;
        s1_zero    = 1'b1;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage 2: saturating update, write-back, forwarding to the next read
  // ---------------------------------------------------------------------------
  kind_e             s2_kind_q;
  logic [TS_W-1:0]   s2_ivl_q;
  logic [SEL_W-1:0]  s2_bin_q;
  logic [BW-1:0]     s2_addr_q;
  logic              s2_zero_q;
  logic              fwd_hit_q;
  logic [CNT_W-1:0]  fwd_data_q;

  logic [CNT_W-1:0]  mem_rd;
  logic [CNT_W-1:0]  cur_cnt;
  logic [CNT_W-1:0]  inc_cnt;
  logic [CNT_W-1:0]  s2_cnt;
  logic [CNT_W-1:0]  total_q;
  logic [CNT_W-1:0]  total_nxt;
  logic              s2_rec;
  logic              wr_en;

  ijh_mem #(
    .DEPTH (NBINS),
    .AW    (BW),
    .DW    (CNT_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (mem_rd),
    .wr_en_i   (wr_en),
    .wr_addr_i (s2_addr_q),
    .wr_data_i (inc_cnt)
  );

  assign s2_rec    = s2_kind_q == KIND_REC;
  assign cur_cnt   = fwd_hit_q ? fwd_data_q : mem_rd;
  assign inc_cnt   = (cur_cnt == SAT) ? cur_cnt : cur_cnt + CNT_W'(1);
  assign wr_en     = s2_v_q && s2_rec && adv_out;
  assign total_nxt = (s2_rec && (total_q != SAT)) ? total_q + CNT_W'(1) : total_q;
  assign s2_cnt    = s2_rec ? inc_cnt : (s2_zero_q ? '0 : cur_cnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      total_q <= '0;
    end else begin
      if (adv2) begin
        s2_v_q <= s1_v_q;
      end
      if (wr_en) begin
        total_q <= total_nxt;
      end
    end
  end

  // the read at this edge misses the write at this edge; keep the new value
  always_ff @(posedge clk_i) begin
    if (adv2) begin
      s2_kind_q  <= s1_kind_q;
      s2_ivl_q   <= s1_ivl_q;
      s2_bin_q   <= s1_bin_out;
      s2_addr_q  <= rd_addr;
      s2_zero_q  <= s1_zero;
      fwd_hit_q  <= wr_en && (s2_addr_q == rd_addr);
      fwd_data_q <= inc_cnt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic              out_rec_q;
  logic [SEL_W-1:0]  out_bin_q;
  logic [CNT_W-1:0]  out_cnt_q;
  logic [CNT_W-1:0]  out_tot_q;
  logic [TS_W-1:0]   out_ivl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv_out) begin
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out) begin
      out_rec_q <= s2_rec;
      out_bin_q <= s2_bin_q;
      out_cnt_q <= s2_cnt;
      out_tot_q <= total_nxt;
      out_ivl_q <= s2_ivl_q;
    end
  end

  assign m_axis_tvalid   = out_v_q;
  assign m_axis_tuser[0] = out_rec_q;
  assign m_axis_tdata    = {4'd0, out_ivl_q, out_tot_q, out_cnt_q, out_bin_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `IJH_ASSERT(a_rec_counts_nonzero,
    (m_axis_tvalid && m_axis_tuser[0]) |-> (out_cnt_q != '0 && out_tot_q != '0),
    "recorded interval with a zero bin count or total")
  `IJH_ASSERT(a_ivl_only_when_rec,
    (m_axis_tvalid && out_ivl_q != '0) |-> m_axis_tuser[0],
    "nonzero interval on a transaction that recorded nothing")
  `IJH_ASSERT(a_accept_has_room,
    in_acc |-> (!s1_v_q || adv2),
    "input accepted while capture stage is blocked")
  `IJH_ASSERT(a_write_in_range,
    wr_en |-> (32'(s2_addr_q) < 32'(NBINS)),
    "bin memory write beyond the last bin")
  `IJH_ASSERT_RST(a_reset_empty,
    !rst_ni |=> (!out_v_q && !s1_v_q && !s2_v_q),
    "pipeline holds a transaction during reset")

endmodule
